>>> rtl/json_number_scanner_assert.svh
// ----------------------------------------------------------------------------
// JSON number scanner assertion macros
// Concurrent assertion wrappers shared by the scanner RTL; ASSERT_OFF
// removes them.
// ----------------------------------------------------------------------------
`ifndef JSON_NUMBER_SCANNER_ASSERT_SVH
`define JSON_NUMBER_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define JNS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define JNS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define JNS_ASSERT(label, prop, msg)
`define JNS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/jns_pkg.sv
// ----------------------------------------------------------------------------
// JSON number scanner package
// Types, constants and helper functions shared by the scanner modules.
// ----------------------------------------------------------------------------
package jns_pkg;

  localparam int SigCntW = 5;
  localparam int IntCntW = 8;
  localparam int ExpAccW = 10;
  localparam int LenW    = 16;
  localparam int ExpOutW = 12;

  localparam logic [SigCntW-1:0] SigDigits = 5'd19;
  localparam logic [IntCntW-1:0] IntDigits = 8'd19;
  localparam logic [IntCntW-1:0] CountMax  = 8'd255;
  localparam logic [ExpAccW-1:0] ExpClamp  = 10'd999;
  localparam logic [LenW-1:0]    LenMax    = 16'hFFFF;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharUpE   = 8'h45;
  localparam logic [7:0] CharLowE  = 8'h65;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_MINUS = 8'b0000_0010,
    PH_INT   = 8'b0000_0100,
    PH_DOT   = 8'b0000_1000,
    PH_FRAC  = 8'b0001_0000,
    PH_E     = 8'b0010_0000,
    PH_ESIGN = 8'b0100_0000,
    PH_EXP   = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ST_INTEGER   = 3'd0,
    ST_DECIMAL   = 3'd1,
    ST_UNEXP_END = 3'd2,
    ST_INVALID   = 3'd3,
    ST_LEAD_ZERO = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef struct packed {
    phase_e             phase;
    logic               sign_seen;
    logic [63:0]        sig_accum;
    logic [SigCntW-1:0] sig_count;
    logic [IntCntW-1:0] int_digit_count;
    logic [63:0]        int_accum;
    logic [SigCntW-1:0] frac_taken;
    logic [ExpAccW-1:0] exp_accum;
    logic               exp_minus;
    logic               first_zero;
    logic [LenW-1:0]    char_count;
    logic               result_given;
  } scan_state_t;

  // Request to close the current number and form a result.
  typedef struct packed {
    logic fire;
    logic lead_zero;
    logic at_end;
  } concl_t;

  typedef struct packed {
    status_e                    status;
    logic                       is_negative;
    logic [63:0]                int_value;
    logic [63:0]                significand;
    logic signed [ExpOutW-1:0]  decimal_exponent;
    logic [LenW-1:0]            length_used;
  } result_t;

  localparam scan_state_t ScanReset = '{
    phase:           PH_START,
    sign_seen:       1'b0,
    sig_accum:       64'd0,
    sig_count:       '0,
    int_digit_count: '0,
    int_accum:       64'd0,
    frac_taken:      '0,
    exp_accum:       '0,
    exp_minus:       1'b0,
    first_zero:      1'b0,
    char_count:      '0,
    result_given:    1'b0
  };

  // acc * 10 + digit, wrapping at 64 bits.
  function automatic logic [63:0] mac10(input logic [63:0] acc, input logic [3:0] digit);
    return (acc << 3) + (acc << 1) + {60'd0, digit};
  endfunction

endpackage

>>> rtl/jns_in_if.sv
// ----------------------------------------------------------------------------
// JSON number scanner input channel
// Valid/ready channel carrying one text byte or the end mark per word.
// ----------------------------------------------------------------------------
interface jns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_mark;

  modport source (output valid, output text_byte, output end_mark, input ready);
  modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

>>> rtl/jns_out_if.sv
// ----------------------------------------------------------------------------
// JSON number scanner result channel
// Valid/ready channel carrying one scan result per word.
// ----------------------------------------------------------------------------
interface jns_out_if;
  logic                                  valid;
  logic                                  ready;
  jns_pkg::status_e                      status;
  logic                                  is_negative;
  logic signed [63:0]                    int_value;
  logic [63:0]                           significand;
  logic signed [jns_pkg::ExpOutW-1:0]    decimal_exponent;
  logic [jns_pkg::LenW-1:0]              length_used;

  modport source (output valid, output status, output is_negative, output int_value,
                  output significand, output decimal_exponent, output length_used,
                  input ready);
  modport sink   (input valid, input status, input is_negative, input int_value,
                  input significand, input decimal_exponent, input length_used,
                  output ready);
endinterface

>>> rtl/jns_core.sv
// ----------------------------------------------------------------------------
// JSON number scanner grammar core
// Scan state registers and the per-byte grammar step.
// ----------------------------------------------------------------------------
`include "json_number_scanner_assert.svh"

module jns_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_mark_i,
  output jns_pkg::scan_state_t state_o,
  output jns_pkg::concl_t      concl_o
);

  jns_pkg::scan_state_t s_q, s_d;
  jns_pkg::scan_state_t int_step, frac_step, exp_step;
  jns_pkg::concl_t      concl;

  logic                        is_dig;
  logic [3:0]                  digit;
  logic                        is_exp_char;
  logic [jns_pkg::LenW-1:0]    len_inc;
  logic [13:0]                 exp_mac;

  assign is_dig      = (text_byte_i >= jns_pkg::CharZero) && (text_byte_i <= jns_pkg::CharNine);
  assign digit       = is_dig ? text_byte_i[3:0] : 4'd0;
  assign is_exp_char = (text_byte_i == jns_pkg::CharUpE) || (text_byte_i == jns_pkg::CharLowE);
  assign len_inc     = (s_q.char_count != jns_pkg::LenMax) ? s_q.char_count + 1'b1
                                                           : s_q.char_count;
  assign exp_mac     = ({4'd0, s_q.exp_accum} << 3) + ({4'd0, s_q.exp_accum} << 1)
                     + {10'd0, digit};

  // State after an integer digit.
  always_comb begin
    int_step = s_q;
    if (s_q.int_digit_count < jns_pkg::IntDigits) begin
      int_step.int_accum = jns_pkg::mac10(s_q.int_accum, digit);
    end
    if (s_q.int_digit_count < jns_pkg::CountMax) begin
      int_step.int_digit_count = s_q.int_digit_count + 1'b1;
    end
    if (s_q.sig_count < jns_pkg::SigDigits) begin
      int_step.sig_accum = jns_pkg::mac10(s_q.sig_accum, digit);
      int_step.sig_count = s_q.sig_count + 1'b1;
    end
    int_step.char_count = len_inc;
    int_step.phase      = jns_pkg::PH_INT;
  end

  // State after a fraction digit.
  always_comb begin
    frac_step = s_q;
    if (s_q.sig_count < jns_pkg::SigDigits) begin
      frac_step.sig_accum  = jns_pkg::mac10(s_q.sig_accum, digit);
      frac_step.sig_count  = s_q.sig_count + 1'b1;
      frac_step.frac_taken = s_q.frac_taken + 1'b1;
    end
    frac_step.char_count = len_inc;
    frac_step.phase      = jns_pkg::PH_FRAC;
  end

  // State after an exponent digit; the value clamps.
  always_comb begin
    exp_step = s_q;
    exp_step.exp_accum  = (exp_mac > {4'd0, jns_pkg::ExpClamp}) ? jns_pkg::ExpClamp
                                                                 : exp_mac[9:0];
    exp_step.char_count = len_inc;
    exp_step.phase      = jns_pkg::PH_EXP;
  end

  always_comb begin
    s_d   = s_q;
    concl = '0;
    if (step_i) begin
      if (end_mark_i) begin
        concl.fire   = !s_q.result_given;
        concl.at_end = 1'b1;
        s_d          = jns_pkg::ScanReset;
      end else if (!s_q.result_given) begin
        unique case (s_q.phase)
          jns_pkg::PH_START, jns_pkg::PH_MINUS: begin
            if ((s_q.phase == jns_pkg::PH_START) && (text_byte_i == jns_pkg::CharMinus)) begin
              s_d.sign_seen  = 1'b1;
              s_d.char_count = len_inc;
              s_d.phase      = jns_pkg::PH_MINUS;
            end else if (!is_dig) begin
              concl.fire = 1'b1;
            end else begin
              s_d            = int_step;
              s_d.first_zero = (digit == 4'd0);
            end
          end
          jns_pkg::PH_INT: begin
            if (is_dig) begin
              if (s_q.first_zero) begin
                concl.fire      = 1'b1;
                concl.lead_zero = 1'b1;
              end else begin
                s_d = int_step;
              end
            end else if (text_byte_i == jns_pkg::CharDot) begin
              s_d.char_count = len_inc;
              s_d.phase      = jns_pkg::PH_DOT;
            end else if (is_exp_char) begin
              s_d.char_count = len_inc;
              s_d.phase      = jns_pkg::PH_E;
            end else begin
              concl.fire = 1'b1;
            end
          end
          jns_pkg::PH_DOT: begin
            if (is_dig) begin
              s_d = frac_step;
            end else begin
              concl.fire = 1'b1;
            end
          end
          jns_pkg::PH_FRAC: begin
            if (is_dig) begin
              s_d = frac_step;
            end else if (is_exp_char) begin
              s_d.char_count = len_inc;
              s_d.phase      = jns_pkg::PH_E;
            end else begin
              concl.fire = 1'b1;
            end
          end
          jns_pkg::PH_E, jns_pkg::PH_ESIGN: begin
            if ((s_q.phase == jns_pkg::PH_E) &&
                ((text_byte_i == jns_pkg::CharPlus) || (text_byte_i == jns_pkg::CharMinus))) begin
              s_d.exp_minus  = (text_byte_i == jns_pkg::CharMinus);
              s_d.char_count = len_inc;
              s_d.phase      = jns_pkg::PH_ESIGN;
            end else if (is_dig) begin
              s_d = exp_step;
            end else begin
              concl.fire = 1'b1;
            end
          end
          jns_pkg::PH_EXP: begin
            if (is_dig) begin
              s_d = exp_step;
            end else begin
              concl.fire = 1'b1;
            end
          end
          default: begin
            concl.fire = 1'b1;
          end
        endcase
        if (concl.fire) begin
          s_d              = s_q;
          s_d.result_given = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= jns_pkg::ScanReset;
    end else begin
      s_q <= s_d;
    end
  end

  assign state_o = s_q;
  assign concl_o = concl;

  `JNS_ASSERT(a_quiet_after_result, step_i && !end_mark_i && s_q.result_given |-> !concl.fire, "result given twice for one number")
  `JNS_ASSERT(a_end_clears, step_i && end_mark_i |=> s_q.phase == jns_pkg::PH_START && !s_q.result_given && s_q.char_count == '0, "end mark did not return scanner to start")
  `JNS_ASSERT(a_fire_marks, step_i && !end_mark_i && concl.fire |=> s_q.result_given, "result not recorded after firing")
  `JNS_ASSERT_ALWAYS(a_sig_count_bound, s_q.sig_count <= jns_pkg::SigDigits && s_q.frac_taken <= s_q.sig_count, "significand digit count out of range")

endmodule

>>> rtl/jns_emit.sv
// ----------------------------------------------------------------------------
// JSON number scanner result formation
// Turns the scan state at the close of a number into a result word.
// ----------------------------------------------------------------------------
module jns_emit (
  input  jns_pkg::scan_state_t state_i,
  input  jns_pkg::concl_t      concl_i,
  output jns_pkg::result_t     result_o
);

  logic                                 overflow;
  logic [63:0]                          int_neg;
  logic [jns_pkg::IntCntW-1:0]          sig_limit;
  logic [jns_pkg::IntCntW-1:0]          taken;
  logic [jns_pkg::IntCntW-1:0]          excess;
  logic signed [jns_pkg::ExpOutW-1:0]   exp_part;
  logic signed [jns_pkg::ExpOutW-1:0]   exp_total;
  jns_pkg::status_e                     status;

  // Magnitude limit is 2^63 for a negative number and 2^63 - 1 otherwise.
  assign overflow = (state_i.int_digit_count > jns_pkg::IntDigits) ||
                    (state_i.sign_seen ? (state_i.int_accum[63] && |state_i.int_accum[62:0])
                                       : state_i.int_accum[63]);
  assign int_neg  = ~state_i.int_accum + 64'd1;

  // Integer digits beyond the significand width scale the result up.
  assign sig_limit = {{(jns_pkg::IntCntW-jns_pkg::SigCntW){1'b0}}, jns_pkg::SigDigits};
  assign taken     = (state_i.int_digit_count < sig_limit) ? state_i.int_digit_count
                                                           : sig_limit;
  assign excess   = state_i.int_digit_count - taken;
  assign exp_part = state_i.exp_minus ? -$signed({2'b00, state_i.exp_accum})
                                      :  $signed({2'b00, state_i.exp_accum});
  assign exp_total = $signed({4'd0, excess}) - $signed({7'd0, state_i.frac_taken}) + exp_part;

  always_comb begin
    priority if (concl_i.lead_zero) begin
      status = jns_pkg::ST_LEAD_ZERO;
    end else begin
      unique case (state_i.phase)
        jns_pkg::PH_START, jns_pkg::PH_MINUS:
          status = concl_i.at_end ? jns_pkg::ST_UNEXP_END : jns_pkg::ST_INVALID;
        jns_pkg::PH_INT:
          status = overflow ? jns_pkg::ST_OVERFLOW : jns_pkg::ST_INTEGER;
        jns_pkg::PH_FRAC, jns_pkg::PH_EXP:
          status = jns_pkg::ST_DECIMAL;
        default:
          status = jns_pkg::ST_INVALID;
      endcase
    end
  end

  always_comb begin
    result_o                  = '0;
    result_o.status           = status;
    result_o.is_negative      = state_i.sign_seen;
    result_o.length_used      = state_i.char_count;
    if (status == jns_pkg::ST_INTEGER) begin
      result_o.int_value = state_i.sign_seen ? int_neg : state_i.int_accum;
    end
    if (status == jns_pkg::ST_DECIMAL) begin
      result_o.significand      = state_i.sig_accum;
      result_o.decimal_exponent = exp_total;
    end
  end

endmodule

>>> rtl/json_number_scanner.sv
// ----------------------------------------------------------------------------
// JSON number scanner
// Byte-stream checker for the JSON number grammar giving one result per number.
// ----------------------------------------------------------------------------
// The scanner takes one word per cycle on in_i when not stalled, each either a
// text byte or the end mark, and gives at most one word on out_o for each
// number: a checked signed 64-bit integer, a decimal (19-digit significand
// with a power-of-ten exponent) or an error status. A number closes at the
// first byte that cannot continue it or at the end mark; bytes after a result
// are dropped until the end mark, which returns the scanner to its start state.
// A word passes through an input register and then the grammar step, which
// updates the scan state and, when the number closes, loads the result
// register, from which the result is presented on out_o. The sustained rate
// is one word per cycle, since the grammar step is a single pass, and the
// input side stalls only while a result is waiting and the input register
// behind it holds a word.
`include "json_number_scanner_assert.svh"

module json_number_scanner (
  input  logic      clk_i,
  input  logic      rst_ni,
  jns_in_if.sink    in_i,
  jns_out_if.source out_o
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  jns_pkg::result_t out_q;

  jns_pkg::scan_state_t state;
  jns_pkg::concl_t      concl;
  jns_pkg::result_t     result;

  logic advance;  // the grammar step may consume the registered word
  logic proc;     // a registered word is consumed this cycle
  logic in_ready;

  assign advance  = !out_valid_q || out_o.ready;
  assign proc     = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  assign in_valid_d = in_ready ? in_i.valid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_byte_q <= in_i.text_byte;
      in_end_q  <= in_i.end_mark;
    end
  end

  jns_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (proc),
    .text_byte_i (in_byte_q),
    .end_mark_i  (in_end_q),
    .state_o     (state),
    .concl_o     (concl)
  );

  // The result is formed from the state before the closing word, which is
  // what the length and value must reflect.
  jns_emit u_emit (
    .state_i  (state),
    .concl_i  (concl),
    .result_o (result)
  );

  always_comb begin
    if (proc && concl.fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && concl.fire) begin
      out_q <= result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_q.status;
  assign out_o.is_negative      = out_q.is_negative;
  assign out_o.int_value        = out_q.int_value;
  assign out_o.significand      = out_q.significand;
  assign out_o.decimal_exponent = out_q.decimal_exponent;
  assign out_o.length_used      = out_q.length_used;

  `JNS_ASSERT(a_no_step_on_stall, out_valid_q && !out_o.ready |-> !proc, "word consumed while a result is blocked")
  `JNS_ASSERT(a_result_has_cause, $rose(out_valid_q) |-> $past(proc && concl.fire), "result appeared without a closing word")
  `JNS_ASSERT(a_input_held, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_end_q), "registered word lost during stall")

endmodule
